### rtl/i2cmts_pkg.sv
// Shared types and constants for the I2C master transaction sequencer.
package i2cmts_pkg;

   localparam int BUF_DEPTH = 32;
   localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int POS_W = $clog2(BUF_DEPTH + 1);
   localparam int CNT_W = (POS_W > 7) ? POS_W : 7;

   localparam logic [15:0] TIMEOUT_RESET = 16'd20000;

   // configuration register indexes
   localparam logic [2:0] CSR_TARGET_ADDRESS = 3'd0;
   localparam logic [2:0] CSR_STOP_WHEN_DONE = 3'd1;
   localparam logic [2:0] CSR_PREFIX_COUNT   = 3'd2;
   localparam logic [2:0] CSR_DATA_COUNT     = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_LIMIT  = 3'd4;

   // command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_EVENT = 2'd3;

   // acknowledge control codes
   localparam logic [1:0] ACK_KEEP  = 2'd0;
   localparam logic [1:0] ACK_SET   = 2'd1;
   localparam logic [1:0] ACK_CLEAR = 2'd2;

   // outcome and error kind codes
   localparam logic [1:0] OUT_BUSY    = 2'd0;
   localparam logic [1:0] OUT_DONE    = 2'd1;
   localparam logic [1:0] OUT_BUS     = 2'd2;
   localparam logic [1:0] OUT_TIMEOUT = 2'd3;
   localparam logic [1:0] ERR_NONE    = 2'd0;

   typedef struct packed {
      logic [6:0]  target_address;
      logic        stop_when_done;
      logic [5:0]  prefix_count;
      logic [5:0]  data_count;
      logic [15:0] timeout_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] status;
      logic [7:0] byte_value;
      logic [4:0] byte_index;
   } item_type;

   typedef struct packed {
      logic       set_start;
      logic       clear_start;
      logic       set_stop;
      logic [1:0] ack_control;
      logic       clear_interrupt;
      logic       write_valid;
      logic [7:0] write_byte;
      logic       rx_valid;
      logic [4:0] rx_index;
      logic [1:0] outcome;
      logic [2:0] fail_phase;
      logic [7:0] fail_status;
   } rsp_type;

endpackage

### rtl/i2c_master_transaction_sequencer_core.sv
// An accepted req beat passes the input register, then the result register, to its rsp beat.
// Throughput: one beat per cycle; the input register advances whenever the result register
// is empty or its rsp beat is taken, so a req beat can be taken in the same cycle as a rsp beat.
// Reset (synchronous, active high): empties both registers, phase idle, no latched error,
// configuration at its reset values; the transmit store keeps its contents.
module i2c_master_transaction_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_status,
   input  logic [7:0]  req_byte_value,
   input  logic [4:0]  req_byte_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_set_start,
   output logic        rsp_clear_start,
   output logic        rsp_set_stop,
   output logic [1:0]  rsp_ack_control,
   output logic        rsp_clear_interrupt,
   output logic        rsp_write_valid,
   output logic [7:0]  rsp_write_byte,
   output logic        rsp_rx_valid,
   output logic [4:0]  rsp_rx_index,
   output logic [1:0]  rsp_outcome,
   output logic [2:0]  rsp_fail_phase,
   output logic [7:0]  rsp_fail_status,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic                 req_valid_ff;
   i2cmts_pkg::item_type item_ff;
   logic                 rsp_valid_ff;
   i2cmts_pkg::rsp_type  rsp_ff, rsp_in;
   i2cmts_pkg::cfg_type  cfg_ff;
   logic                 advance;

   // process the held beat whenever the result register can take it
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= '{cmd: req_cmd, status: req_status, byte_value: req_byte_value,
                      byte_index: req_byte_index};
      end
   end

   i2cmts_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (item_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_address <= '0;
         cfg_ff.stop_when_done <= 1'b1;
         cfg_ff.prefix_count   <= '0;
         cfg_ff.data_count     <= '0;
         cfg_ff.timeout_limit  <= i2cmts_pkg::TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            i2cmts_pkg::CSR_TARGET_ADDRESS: cfg_ff.target_address <= csr_write_data[6:0];
            i2cmts_pkg::CSR_STOP_WHEN_DONE: cfg_ff.stop_when_done <= csr_write_data[0];
            i2cmts_pkg::CSR_PREFIX_COUNT:   cfg_ff.prefix_count   <= csr_write_data[5:0];
            i2cmts_pkg::CSR_DATA_COUNT:     cfg_ff.data_count     <= csr_write_data[5:0];
            i2cmts_pkg::CSR_TIMEOUT_LIMIT:  cfg_ff.timeout_limit  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_set_start       = rsp_ff.set_start;
   assign rsp_clear_start     = rsp_ff.clear_start;
   assign rsp_set_stop        = rsp_ff.set_stop;
   assign rsp_ack_control     = rsp_ff.ack_control;
   assign rsp_clear_interrupt = rsp_ff.clear_interrupt;
   assign rsp_write_valid     = rsp_ff.write_valid;
   assign rsp_write_byte      = rsp_ff.write_byte;
   assign rsp_rx_valid        = rsp_ff.rx_valid;
   assign rsp_rx_index        = rsp_ff.rx_index;
   assign rsp_outcome         = rsp_ff.outcome;
   assign rsp_fail_phase      = rsp_ff.fail_phase;
   assign rsp_fail_status     = rsp_ff.fail_status;

endmodule

### rtl/i2cmts_engine.sv
// Transaction state, transmit store and per-beat action decode.
module i2cmts_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  i2cmts_pkg::item_type item,
   input  i2cmts_pkg::cfg_type  cfg,
   output i2cmts_pkg::rsp_type  rsp
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ERROR   = 3'd1;
   localparam logic [2:0] PH_W_START = 3'd2;
   localparam logic [2:0] PH_W_ADDR  = 3'd3;
   localparam logic [2:0] PH_W_DATA  = 3'd4;
   localparam logic [2:0] PH_R_START = 3'd5;
   localparam logic [2:0] PH_R_ADDR  = 3'd6;
   localparam logic [2:0] PH_R_DATA  = 3'd7;

   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RESTART   = 8'h10;
   localparam logic [7:0] ST_W_ADDR_OK = 8'h18;
   localparam logic [7:0] ST_W_ADDR_NK = 8'h20;
   localparam logic [7:0] ST_W_DATA_OK = 8'h28;
   localparam logic [7:0] ST_W_DATA_NK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_R_ADDR_OK = 8'h40;
   localparam logic [7:0] ST_R_ADDR_NK = 8'h48;
   localparam logic [7:0] ST_R_DATA_OK = 8'h50;
   localparam logic [7:0] ST_R_DATA_NK = 8'h58;

   localparam int CNT_W = i2cmts_pkg::CNT_W;
   localparam int POS_W = i2cmts_pkg::POS_W;
   localparam int IDX_W = i2cmts_pkg::IDX_W;

   logic [2:0]       phase_ff, phase_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [16:0]      wait_count_ff, wait_count_in;
   logic [1:0]       error_kind_ff, error_kind_in;
   logic [2:0]       error_phase_ff, error_phase_in;
   logic [7:0]       error_status_ff, error_status_in;
   logic [7:0]       tx_store_ff [i2cmts_pkg::BUF_DEPTH];

   logic             store_we;
   logic [CNT_W-1:0] pos_c, wr_total, rd_total, sum_c, depth_c;
   logic [16:0]      wait_inc;
   logic             fail;
   logic [1:0]       fail_kind;
   i2cmts_pkg::rsp_type r;

   assign depth_c  = CNT_W'(i2cmts_pkg::BUF_DEPTH);
   assign pos_c    = CNT_W'(position_ff);
   assign sum_c    = CNT_W'(cfg.prefix_count) + CNT_W'(cfg.data_count);
   assign wr_total = (sum_c > depth_c) ? depth_c : sum_c;
   assign rd_total = (CNT_W'(cfg.data_count) > depth_c) ? depth_c : CNT_W'(cfg.data_count);
   assign wait_inc = wait_count_ff + 17'd1;

   always_comb begin
      phase_in        = phase_ff;
      position_in     = position_ff;
      wait_count_in   = wait_count_ff;
      error_kind_in   = error_kind_ff;
      error_phase_in  = error_phase_ff;
      error_status_in = error_status_ff;
      store_we        = 1'b0;
      fail            = 1'b0;
      fail_kind       = i2cmts_pkg::OUT_BUS;
      r               = '0;

      case (item.cmd)
         i2cmts_pkg::CMD_LOAD: begin
            store_we = CNT_W'(item.byte_index) < depth_c;
         end
         i2cmts_pkg::CMD_WRITE, i2cmts_pkg::CMD_READ: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_ERROR) begin
               error_kind_in   = i2cmts_pkg::ERR_NONE;
               error_phase_in  = PH_IDLE;
               error_status_in = 8'hFF;
               position_in     = '0;
               wait_count_in   = '0;
               phase_in        = (item.cmd == i2cmts_pkg::CMD_WRITE) ? PH_W_START : PH_R_START;
               r.ack_control   = i2cmts_pkg::ACK_CLEAR;
               r.set_start     = 1'b1;
            end
         end
         default: begin
            unique case (phase_ff) inside
               PH_W_START, PH_R_START: begin
                  if (item.status == ST_START || item.status == ST_RESTART) begin
                     wait_count_in     = '0;
                     phase_in          = (phase_ff == PH_R_START) ? PH_R_ADDR : PH_W_ADDR;
                     r.clear_start     = 1'b1;
                     r.write_valid     = 1'b1;
                     r.write_byte      = {cfg.target_address, phase_ff == PH_R_START};
                     r.clear_interrupt = 1'b1;
                  end else if (item.status == ST_W_ADDR_NK || item.status == ST_ARB_LOST) begin
                     fail = 1'b1;
                  end else begin
                     wait_count_in = wait_inc;
                     if (wait_inc > 17'(cfg.timeout_limit)) begin
                        fail      = 1'b1;
                        fail_kind = i2cmts_pkg::OUT_TIMEOUT;
                     end
                  end
               end
               PH_W_ADDR, PH_W_DATA: begin
                  if (item.status == ST_W_ADDR_OK || item.status == ST_W_DATA_OK) begin
                     r.clear_interrupt = 1'b1;
                     if (pos_c >= wr_total) begin
                        r.set_stop = cfg.stop_when_done;
                        phase_in   = PH_IDLE;
                     end else begin
                        r.write_valid = 1'b1;
                        r.write_byte  = tx_store_ff[position_ff[IDX_W-1:0]];
                        position_in   = position_ff + POS_W'(1);
                        wait_count_in = '0;
                        phase_in      = PH_W_DATA;
                     end
                  end else if (item.status == ST_W_ADDR_NK || item.status == ST_W_DATA_NK
                               || item.status == ST_ARB_LOST) begin
                     fail = 1'b1;
                  end else begin
                     wait_count_in = wait_inc;
                     if (wait_inc > 17'(cfg.timeout_limit)) begin
                        fail      = 1'b1;
                        fail_kind = i2cmts_pkg::OUT_TIMEOUT;
                     end
                  end
               end
               PH_R_ADDR, PH_R_DATA: begin
                  if (item.status == ST_R_ADDR_OK || item.status == ST_R_DATA_OK
                      || item.status == ST_R_DATA_NK) begin
                     r.clear_interrupt = 1'b1;
                     if (pos_c >= rd_total) begin
                        r.set_stop = cfg.stop_when_done;
                        phase_in   = PH_IDLE;
                     end else begin
                        // acknowledge decided from the count before this byte
                        r.ack_control = (pos_c + CNT_W'(1) == rd_total) ?
                                        i2cmts_pkg::ACK_CLEAR : i2cmts_pkg::ACK_SET;
                        r.clear_start = 1'b1;
                        if (phase_ff == PH_R_DATA) begin
                           r.rx_valid  = 1'b1;
                           r.rx_index  = 5'(position_ff);
                           position_in = position_ff + POS_W'(1);
                        end
                        phase_in = PH_R_DATA;
                     end
                  end else if (item.status == ST_ARB_LOST || item.status == ST_R_ADDR_NK) begin
                     fail = 1'b1;
                  end else begin
                     wait_count_in = wait_inc;
                     if (wait_inc > 17'(cfg.timeout_limit)) begin
                        fail      = 1'b1;
                        fail_kind = i2cmts_pkg::OUT_TIMEOUT;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      endcase

      // stop the bus and latch the failure
      if (fail) begin
         error_kind_in     = fail_kind;
         error_phase_in    = phase_ff;
         error_status_in   = item.status;
         r.ack_control     = i2cmts_pkg::ACK_CLEAR;
         r.clear_start     = 1'b1;
         r.set_stop        = 1'b1;
         r.clear_interrupt = 1'b1;
         phase_in          = PH_ERROR;
      end

      if (phase_in == PH_IDLE) begin
         r.outcome = i2cmts_pkg::OUT_DONE;
      end else if (phase_in == PH_ERROR) begin
         r.outcome = error_kind_in;
      end else begin
         r.outcome = i2cmts_pkg::OUT_BUSY;
      end
      r.fail_phase  = error_phase_in;
      r.fail_status = error_status_in;
   end

   assign rsp = r;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         position_ff     <= '0;
         wait_count_ff   <= '0;
         error_kind_ff   <= i2cmts_pkg::ERR_NONE;
         error_phase_ff  <= PH_IDLE;
         error_status_ff <= 8'hFF;
      end else if (fire) begin
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         wait_count_ff   <= wait_count_in;
         error_kind_ff   <= error_kind_in;
         error_phase_ff  <= error_phase_in;
         error_status_ff <= error_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && store_we) begin
         tx_store_ff[IDX_W'(item.byte_index)] <= item.byte_value;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> phase_ff == PH_IDLE)
      else $error("phase not idle after reset");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(position_ff) <= depth_c)
      else $error("position beyond buffer depth");

   a_kind_error: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> (error_kind_ff == i2cmts_pkg::OUT_BUS
                                || error_kind_ff == i2cmts_pkg::OUT_TIMEOUT))
      else $error("error phase without error kind");

   a_kind_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_ERROR |-> error_kind_ff == i2cmts_pkg::ERR_NONE)
      else $error("error kind latched outside error phase");

   a_rx_phase: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.rx_valid |-> phase_ff == PH_R_DATA && item.cmd == i2cmts_pkg::CMD_EVENT)
      else $error("received byte reported outside read data phase");

endmodule

### dv/i2c_master_transaction_sequencer_core_test.sv
// Self-checking testbench for the I2C master transaction sequencer core.
module i2c_master_transaction_sequencer_core_test;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ERROR   = 3'd1;
   localparam logic [2:0] PH_W_START = 3'd2;
   localparam logic [2:0] PH_W_ADDR  = 3'd3;
   localparam logic [2:0] PH_W_DATA  = 3'd4;
   localparam logic [2:0] PH_R_START = 3'd5;
   localparam logic [2:0] PH_R_ADDR  = 3'd6;
   localparam logic [2:0] PH_R_DATA  = 3'd7;

   localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RESTART     = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
   localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
   localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST    = 8'h38;
   localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
   localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
   localparam logic [7:0] ST_NO_INFO     = 8'hF8;

   class sequencer_scoreboard;
      logic [6:0]  target_address;
      logic        stop_when_done;
      logic [5:0]  prefix_count;
      logic [5:0]  data_count;
      logic [15:0] timeout_limit;
      logic [2:0]  phase;
      int          position;
      int          wait_count;
      logic [7:0]  tx_store [i2cmts_pkg::BUF_DEPTH];
      logic [1:0]  error_kind;
      logic [2:0]  error_phase;
      logic [7:0]  error_status;
      i2cmts_pkg::rsp_type pending_actions [$];
      int          mismatches;

      function new();
         target_address = '0;
         stop_when_done = 1'b1;
         prefix_count   = '0;
         data_count     = '0;
         timeout_limit  = i2cmts_pkg::TIMEOUT_RESET;
         phase          = PH_IDLE;
         position       = 0;
         wait_count     = 0;
         error_kind     = i2cmts_pkg::ERR_NONE;
         error_phase    = '0;
         error_status   = 8'hFF;
         mismatches     = 0;
         foreach (tx_store[i]) tx_store[i] = '0;
      endfunction

      function void write_reg(logic [2:0] index, logic [15:0] data);
         case (index)
            i2cmts_pkg::CSR_TARGET_ADDRESS: target_address = data[6:0];
            i2cmts_pkg::CSR_STOP_WHEN_DONE: stop_when_done = data[0];
            i2cmts_pkg::CSR_PREFIX_COUNT:   prefix_count = data[5:0];
            i2cmts_pkg::CSR_DATA_COUNT:     data_count = data[5:0];
            i2cmts_pkg::CSR_TIMEOUT_LIMIT:  timeout_limit = data;
            default: ;
         endcase
      endfunction

      function bit in_transfer();
         return phase != PH_IDLE && phase != PH_ERROR;
      endfunction

      function void latch_error(logic [1:0] kind, logic [7:0] st,
                                inout i2cmts_pkg::rsp_type r);
         error_kind        = kind;
         error_phase       = phase;
         error_status      = st;
         r.ack_control     = i2cmts_pkg::ACK_CLEAR;
         r.clear_start     = 1'b1;
         r.set_stop        = 1'b1;
         r.clear_interrupt = 1'b1;
         phase             = PH_ERROR;
      endfunction

      function void count_miss(logic [7:0] st, inout i2cmts_pkg::rsp_type r);
         wait_count++;
         if (wait_count > int'(timeout_limit)) latch_error(i2cmts_pkg::OUT_TIMEOUT, st, r);
      endfunction

      // Work out the controller actions for one accepted req beat.
      function void predict_actions(i2cmts_pkg::item_type it);
         i2cmts_pkg::rsp_type r;
         int      total;
         bit      rd;
         r = '0;
         case (it.cmd)
            i2cmts_pkg::CMD_LOAD: tx_store[it.byte_index] = it.byte_value;
            i2cmts_pkg::CMD_WRITE, i2cmts_pkg::CMD_READ: begin
               if (!in_transfer()) begin
                  error_kind    = i2cmts_pkg::ERR_NONE;
                  error_phase   = '0;
                  error_status  = 8'hFF;
                  position      = 0;
                  wait_count    = 0;
                  phase         = (it.cmd == i2cmts_pkg::CMD_WRITE) ? PH_W_START : PH_R_START;
                  r.ack_control = i2cmts_pkg::ACK_CLEAR;
                  r.set_start   = 1'b1;
               end
            end
            default: begin
               case (phase)
                  PH_W_START, PH_R_START: begin
                     if (it.status == ST_START || it.status == ST_RESTART) begin
                        rd                = (phase == PH_R_START);
                        wait_count        = 0;
                        phase             = rd ? PH_R_ADDR : PH_W_ADDR;
                        r.clear_start     = 1'b1;
                        r.write_valid     = 1'b1;
                        r.write_byte      = {target_address, rd};
                        r.clear_interrupt = 1'b1;
                     end else if (it.status == ST_SLA_W_NACK || it.status == ST_ARB_LOST) begin
                        latch_error(i2cmts_pkg::OUT_BUS, it.status, r);
                     end else begin
                        count_miss(it.status, r);
                     end
                  end
                  PH_W_ADDR, PH_W_DATA: begin
                     if (it.status == ST_SLA_W_ACK || it.status == ST_DATA_W_ACK) begin
                        total = prefix_count + data_count;
                        if (total > i2cmts_pkg::BUF_DEPTH) total = i2cmts_pkg::BUF_DEPTH;
                        r.clear_interrupt = 1'b1;
                        if (position >= total) begin
                           r.set_stop = stop_when_done;
                           phase      = PH_IDLE;
                        end else begin
                           r.write_valid = 1'b1;
                           r.write_byte  = tx_store[position];
                           position++;
                           wait_count    = 0;
                           phase         = PH_W_DATA;
                        end
                     end else if (it.status == ST_SLA_W_NACK || it.status == ST_DATA_W_NACK ||
                                  it.status == ST_ARB_LOST) begin
                        latch_error(i2cmts_pkg::OUT_BUS, it.status, r);
                     end else begin
                        count_miss(it.status, r);
                     end
                  end
                  PH_R_ADDR, PH_R_DATA: begin
                     if (it.status == ST_SLA_R_ACK || it.status == ST_DATA_R_ACK ||
                         it.status == ST_DATA_R_NACK) begin
                        total = data_count;
                        if (total > i2cmts_pkg::BUF_DEPTH) total = i2cmts_pkg::BUF_DEPTH;
                        r.clear_interrupt = 1'b1;
                        if (position >= total) begin
                           r.set_stop = stop_when_done;
                           phase      = PH_IDLE;
                        end else begin
                           // acknowledge is decided before this byte is counted
                           r.ack_control = (position + 1 == total) ? i2cmts_pkg::ACK_CLEAR
                                                                   : i2cmts_pkg::ACK_SET;
                           r.clear_start = 1'b1;
                           if (phase == PH_R_DATA) begin
                              r.rx_valid = 1'b1;
                              r.rx_index = position[4:0];
                              position++;
                           end
                           phase = PH_R_DATA;
                        end
                     end else if (it.status == ST_ARB_LOST || it.status == ST_SLA_R_NACK) begin
                        latch_error(i2cmts_pkg::OUT_BUS, it.status, r);
                     end else begin
                        count_miss(it.status, r);
                     end
                  end
                  default: ;
               endcase
            end
         endcase
         if (phase == PH_IDLE) r.outcome = i2cmts_pkg::OUT_DONE;
         else if (phase == PH_ERROR) r.outcome = error_kind;
         else r.outcome = i2cmts_pkg::OUT_BUSY;
         r.fail_phase  = error_phase;
         r.fail_status = error_status;
         pending_actions.push_back(r);
      endfunction

      function string show(i2cmts_pkg::rsp_type r);
         return $sformatf({"set_start=%0d clear_start=%0d set_stop=%0d ack=%0d clr_int=%0d ",
                           "wr=%0d/%02h rx=%0d/%0d outcome=%0d fail=%0d/%02h"},
                          r.set_start, r.clear_start, r.set_stop, r.ack_control,
                          r.clear_interrupt, r.write_valid, r.write_byte, r.rx_valid,
                          r.rx_index, r.outcome, r.fail_phase, r.fail_status);
      endfunction

      function void check_actions(i2cmts_pkg::rsp_type got);
         i2cmts_pkg::rsp_type want;
         if (pending_actions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("rsp beat with nothing pending: %s", show(got));
            return;
         end
         want = pending_actions.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch\n  expected %s\n  actual   %s", show(want), show(got));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = i2cmts_pkg::CMD_LOAD;
   logic [7:0]  req_status = '0;
   logic [7:0]  req_byte_value = '0;
   logic [4:0]  req_byte_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_set_start;
   logic        rsp_clear_start;
   logic        rsp_set_stop;
   logic [1:0]  rsp_ack_control;
   logic        rsp_clear_interrupt;
   logic        rsp_write_valid;
   logic [7:0]  rsp_write_byte;
   logic        rsp_rx_valid;
   logic [4:0]  rsp_rx_index;
   logic [1:0]  rsp_outcome;
   logic [2:0]  rsp_fail_phase;
   logic [7:0]  rsp_fail_status;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = i2cmts_pkg::CSR_TARGET_ADDRESS;
   logic [15:0] csr_write_data = '0;

   sequencer_scoreboard sb;
   int sender_pct = 0;
   int receiver_pct = 0;
   int beats_sent = 0;

   i2c_master_transaction_sequencer_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_status          (req_status),
      .req_byte_value      (req_byte_value),
      .req_byte_index      (req_byte_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_set_start       (rsp_set_start),
      .rsp_clear_start     (rsp_clear_start),
      .rsp_set_stop        (rsp_set_stop),
      .rsp_ack_control     (rsp_ack_control),
      .rsp_clear_interrupt (rsp_clear_interrupt),
      .rsp_write_valid     (rsp_write_valid),
      .rsp_write_byte      (rsp_write_byte),
      .rsp_rx_valid        (rsp_rx_valid),
      .rsp_rx_index        (rsp_rx_index),
      .rsp_outcome         (rsp_outcome),
      .rsp_fail_phase      (rsp_fail_phase),
      .rsp_fail_status     (rsp_fail_status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) sb.write_reg(csr_index, csr_write_data);
         if (req_valid && !req_stall)
            sb.predict_actions({req_cmd, req_status, req_byte_value, req_byte_index});
         if (rsp_valid && !rsp_stall)
            sb.check_actions({rsp_set_start, rsp_clear_start, rsp_set_stop, rsp_ack_control,
                              rsp_clear_interrupt, rsp_write_valid, rsp_write_byte,
                              rsp_rx_valid, rsp_rx_index, rsp_outcome, rsp_fail_phase,
                              rsp_fail_status});
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic push_beat(logic [1:0] cmd, logic [7:0] status, logic [7:0] value,
                            logic [4:0] index);
      while ($urandom_range(0, 99) < sender_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_status     <= status;
      req_byte_value <= value;
      req_byte_index <= index;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   task automatic program_config(logic [6:0] addr, logic stop, logic [5:0] pre,
                                 logic [5:0] dat, logic [15:0] lim);
      write_reg(i2cmts_pkg::CSR_TARGET_ADDRESS, {9'd0, addr});
      write_reg(i2cmts_pkg::CSR_STOP_WHEN_DONE, {15'd0, stop});
      write_reg(i2cmts_pkg::CSR_PREFIX_COUNT, {10'd0, pre});
      write_reg(i2cmts_pkg::CSR_DATA_COUNT, {10'd0, dat});
      write_reg(i2cmts_pkg::CSR_TIMEOUT_LIMIT, lim);
      csr_write_enable <= 1'b0;
   endtask

   // Drop valid and wait until every pending beat has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_actions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_event(logic [7:0] status);
      push_beat(i2cmts_pkg::CMD_EVENT, status, 8'($urandom), 5'($urandom));
   endtask

   // Status that the current phase waits for, or one of its bus-error codes.
   task automatic phase_event(bit fault);
      logic [7:0] st;
      case (sb.phase)
         PH_W_START, PH_R_START: begin
            if (fault) st = $urandom_range(0, 1) ? ST_SLA_W_NACK : ST_ARB_LOST;
            else st = $urandom_range(0, 1) ? ST_START : ST_RESTART;
         end
         PH_W_ADDR, PH_W_DATA: begin
            if (fault) begin
               case ($urandom_range(0, 2))
                  0: st = ST_SLA_W_NACK;
                  1: st = ST_DATA_W_NACK;
                  default: st = ST_ARB_LOST;
               endcase
            end else begin
               st = $urandom_range(0, 1) ? ST_SLA_W_ACK : ST_DATA_W_ACK;
            end
         end
         default: begin
            if (fault) begin
               st = $urandom_range(0, 1) ? ST_ARB_LOST : ST_SLA_R_NACK;
            end else begin
               case ($urandom_range(0, 2))
                  0: st = ST_SLA_R_ACK;
                  1: st = ST_DATA_R_ACK;
                  default: st = ST_DATA_R_NACK;
               endcase
            end
         end
      endcase
      send_event(st);
   endtask

   // One write or read transfer, mostly well formed, with noise mixed in.
   task automatic run_transfer();
      int steps;
      int pick;
      push_beat($urandom_range(0, 1) ? i2cmts_pkg::CMD_READ : i2cmts_pkg::CMD_WRITE,
                8'($urandom), 8'($urandom), 5'($urandom));
      steps = 0;
      while (sb.in_transfer() && steps < 120) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            phase_event(1'b1);
         end else if (pick < 7) begin
            repeat ($urandom_range(1, 5)) send_event(8'($urandom));
         end else if (pick < 10) begin
            push_beat(i2cmts_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 5'($urandom));
         end else if (pick < 12) begin
            push_beat($urandom_range(0, 1) ? i2cmts_pkg::CMD_READ : i2cmts_pkg::CMD_WRITE,
                      8'($urandom), 8'($urandom), 5'($urandom));
         end else begin
            phase_event(1'b0);
         end
         steps++;
      end
   endtask

   initial begin
      int          stop_at;
      logic [6:0]  addr;
      logic [5:0]  pre;
      logic [5:0]  dat;
      logic [15:0] lim;
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole store so no transfer reads an unwritten entry
      for (int i = 0; i < i2cmts_pkg::BUF_DEPTH; i++)
         push_beat(i2cmts_pkg::CMD_LOAD, 8'($urandom),
                   (i == 0) ? 8'h00 : (i == i2cmts_pkg::BUF_DEPTH - 1) ? 8'hFF : 8'($urandom),
                   5'(i));
      settle();

      program_config(7'h7F, 1'b1, 6'd1, 6'd2, 16'd3);
      send_event(ST_START);
      push_beat(i2cmts_pkg::CMD_WRITE, 8'hFF, 8'h00, 5'd0);
      send_event(ST_BUS_ERROR);
      send_event(ST_START);
      send_event(ST_SLA_W_ACK);
      send_event(ST_DATA_W_ACK);
      send_event(ST_DATA_W_ACK);
      send_event(ST_DATA_W_ACK);
      push_beat(i2cmts_pkg::CMD_READ, 8'h00, 8'hFF, 5'd31);
      send_event(ST_RESTART);
      send_event(ST_SLA_R_ACK);
      send_event(ST_DATA_R_ACK);
      send_event(ST_DATA_R_NACK);
      send_event(ST_DATA_R_NACK);
      push_beat(i2cmts_pkg::CMD_WRITE, 8'h00, 8'h00, 5'd0);
      push_beat(i2cmts_pkg::CMD_READ, 8'h00, 8'h00, 5'd0);
      push_beat(i2cmts_pkg::CMD_LOAD, 8'hFF, 8'hFF, 5'd31);
      send_event(ST_ARB_LOST);
      send_event(8'hFF);
      push_beat(i2cmts_pkg::CMD_READ, 8'h00, 8'h00, 5'd0);
      repeat (4) send_event(ST_NO_INFO);
      settle();

      // zero limit times out on the first miss; both counts are set to the store depth
      program_config(7'h00, 1'b0, 6'd32, 6'd32, 16'd0);
      push_beat(i2cmts_pkg::CMD_WRITE, 8'h00, 8'h00, 5'd0);
      send_event(ST_START);
      send_event(ST_NO_INFO);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin
               sender_pct   = 0;
               receiver_pct = 0;
            end
            1: begin
               sender_pct   = 79;
               receiver_pct = 0;
            end
            2: begin
               sender_pct   = 0;
               receiver_pct = 79;
            end
            default: begin
               sender_pct   = 8;
               receiver_pct = 8;
            end
         endcase
         if (p == 0) begin
            program_config(7'($urandom), 1'b1, 6'd0, 6'd0, 16'hFFFF);
         end else if (p == 1) begin
            program_config(7'h7F, 1'b0, 6'd32, 6'd32, 16'd1);
         end else begin
            addr = 7'($urandom);
            pre  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 32))
                                               : 6'($urandom_range(0, 5));
            dat  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 32))
                                               : 6'($urandom_range(0, 5));
            case ($urandom_range(0, 2))
               0: lim = 16'($urandom_range(1, 4));
               1: lim = i2cmts_pkg::TIMEOUT_RESET;
               default: lim = 16'hFFFF;
            endcase
            program_config(addr, 1'($urandom), pre, dat, lim);
         end
         stop_at = beats_sent + 100;
         while (beats_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0)
               push_beat(2'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
            else
               run_transfer();
         end
         settle();
      end

      if (sb.mismatches == 0 && sb.pending_actions.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
